### rtl/core/aim_table_interpolator_assert.svh
// Assertion helpers for the aim table interpolator.
`ifndef AIM_TABLE_INTERPOLATOR_ASSERT_SVH
`define AIM_TABLE_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define AIM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aim_table_interpolator: check failed");
`define AIM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aim_table_interpolator: check failed");
`else
`define AIM_ASSERT_IMP(name, ante, cons)
`define AIM_ASSERT_NXT(name, ante, cons)
`endif

`endif

### rtl/core/aim_ti_pkg.sv
`default_nettype none
package aim_ti_pkg;

  localparam int TABLE_ROWS_DEF = 16;
  localparam int MEDIAN_TAPS    = 5;
  localparam int FILL_W         = $clog2(MEDIAN_TAPS + 1);
  localparam int SLOT_W         = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DIV_STEPS      = 33;

  typedef enum logic [1:0] {
    OP_WRITE_ROW = 2'd0,
    OP_START     = 2'd1,
    OP_SAMPLE    = 2'd2,
    OP_STOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS   = 2'd0,
    CFG_LIMIT  = 2'd1,
    CFG_SETTLE = 2'd2,
    CFG_GAIN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_SAMPLE,
    JOB_STOP
  } job_kind_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MED,
    B_MEDFIN,
    B_RD_HI,
    B_CLAMP,
    B_SCAN,
    B_RD_SEG,
    B_RD_SEG1,
    B_ROW1,
    B_MUL,
    B_DIVLOAD,
    B_DIV,
    B_FIX,
    B_OUT
  } back_state_t;

  typedef struct packed {
    job_kind_t                       kind;
    logic [3:0]                      row_index;
    logic [15:0]                     row_pitch;
    logic [15:0]                     row_angle;
    logic [15:0]                     row_speed;
    logic [FILL_W-1:0]               fill;
    logic [MEDIAN_TAPS-1:0][15:0]    window;
    logic [15:0]                     turret;
    logic                            fire;
  } job_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sh7fff;
    else if (v < -36'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/aim_ti_ifs.sv
`default_nettype none
interface aim_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface aim_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         row_index;
  logic signed [15:0] row_pitch;
  logic signed [15:0] row_angle;
  logic signed [15:0] row_speed;
  logic               has_target;
  logic signed [15:0] pitch;
  logic signed [15:0] horizontal_error;
  logic signed [15:0] turret_position;
  logic signed [15:0] turret_error;
  logic signed [15:0] hood_error;
  modport source (output valid, output op, output row_index, output row_pitch,
                  output row_angle, output row_speed, output has_target, output pitch,
                  output horizontal_error, output turret_position, output turret_error,
                  output hood_error, input ready);
  modport sink (input valid, input op, input row_index, input row_pitch,
                input row_angle, input row_speed, input has_target, input pitch,
                input horizontal_error, input turret_position, input turret_error,
                input hood_error, output ready);
endinterface

interface aim_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hood_setpoint;
  logic signed [15:0] wheel_speed;
  logic signed [15:0] turret_setpoint;
  logic               fire;
  modport source (output valid, output hood_setpoint, output wheel_speed,
                  output turret_setpoint, output fire, input ready);
  modport sink (input valid, input hood_setpoint, input wheel_speed,
                input turret_setpoint, input fire, output ready);
endinterface
`default_nettype wire

### rtl/core/aim_ti_front.sv
`default_nettype none
module aim_ti_front (
  input  logic              clk,
  input  logic              rst,
  aim_cmd_if.sink           cmd,
  input  logic [14:0]       fire_error_limit,
  input  logic [7:0]        settle_count,
  input  logic [7:0]        turret_gain,
  input  logic              q_full,
  output logic              q_push,
  output aim_ti_pkg::job_t  q_job
);
  import aim_ti_pkg::*;

  logic [MEDIAN_TAPS-1:0][15:0] window, window_next;
  logic [FILL_W-1:0]            fill, fill_next;
  logic [SLOT_W-1:0]            slot, slot_next;
  logic [7:0]                   sample_count, count_next;
  logic                         accept;
  op_t                          op;
  logic signed [24:0]           prod;
  logic [23:0]                  prod_mag;
  logic [15:0]                  gq;
  logic signed [35:0]           tsum;
  logic signed [16:0]           te_x, he_x;
  logic [16:0]                  te_mag, he_mag;
  logic                         fire;

  assign cmd.ready = !q_full;

  always_comb begin
    accept = cmd.valid && !q_full;
    op = op_t'(cmd.op);
    window_next = window;
    window_next[slot] = cmd.pitch;
    slot_next = (slot == SLOT_W'(MEDIAN_TAPS - 1)) ? '0 : slot + 1'b1;
    fill_next = (fill == FILL_W'(MEDIAN_TAPS)) ? fill : fill + 1'b1;
    count_next = (sample_count == 8'd255) ? sample_count : sample_count + 8'd1;

    // gained error, rounded half away from zero
    prod = cmd.horizontal_error * $signed({1'b0, turret_gain});
    prod_mag = prod[24] ? 24'(-prod) : prod[23:0];
    gq = 16'((prod_mag + 24'd128) >> 8);
    tsum = 36'(cmd.turret_position) + (prod[24] ? -36'(gq) : 36'(gq));

    te_x = 17'(cmd.turret_error);
    he_x = 17'(cmd.hood_error);
    te_mag = te_x[16] ? 17'(-te_x) : 17'(te_x);
    he_mag = he_x[16] ? 17'(-he_x) : 17'(he_x);
    fire = (te_mag < {2'b00, fire_error_limit}) && (he_mag < {2'b00, fire_error_limit})
           && (count_next >= settle_count);

    q_job = '0;
    q_job.row_index = cmd.row_index;
    q_job.row_pitch = cmd.row_pitch;
    q_job.row_angle = cmd.row_angle;
    q_job.row_speed = cmd.row_speed;
    q_job.fill = fill_next;
    q_job.window = window_next;
    q_job.turret = sat16(tsum);
    q_job.fire = fire;
    q_push = 1'b0;
    q_job.kind = JOB_WRITE;
    case (op)
      OP_WRITE_ROW: begin
        q_push = accept;
        q_job.kind = JOB_WRITE;
      end
      OP_START: q_push = 1'b0;
      OP_SAMPLE: begin
        q_push = accept && cmd.has_target;
        q_job.kind = JOB_SAMPLE;
      end
      OP_STOP: begin
        q_push = accept;
        q_job.kind = JOB_STOP;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      fill <= '0;
      slot <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (op == OP_START) begin
        sample_count <= '0;
      end else if (op == OP_SAMPLE && cmd.has_target) begin
        window <= window_next;
        fill <= fill_next;
        slot <= slot_next;
        sample_count <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/aim_ti_queue.sv
`default_nettype none
module aim_ti_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  aim_ti_pkg::job_t  push_job,
  input  logic              pop,
  output aim_ti_pkg::job_t  pop_job,
  output logic              full,
  output logic              empty
);
  import aim_ti_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [QW:0]   count;

  assign full = (count == (QW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/aim_ti_back.sv
`default_nettype none
module aim_ti_back #(
  parameter int TABLE_ROWS = aim_ti_pkg::TABLE_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [4:0]        rows_in_use,
  input  logic              q_empty,
  output logic              q_pop,
  input  aim_ti_pkg::job_t  q_job,
  aim_res_if.source         result
);
  import aim_ti_pkg::*;

  localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int NW = $clog2(TABLE_ROWS + 1);

  back_state_t state, state_next;

  logic [47:0]        row_mem [TABLE_ROWS];
  logic [47:0]        rdata;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               mem_we;
  logic signed [15:0] rd_pitch, rd_angle, rd_speed;

  job_t               job;
  logic [NW-1:0]      n_rows;
  logic [AW-1:0]      last_row, scan_end, scan_i, seg;
  logic [SLOT_W-1:0]  med_i;
  logic [FILL_W-1:0]  rank, half;
  logic signed [15:0] w_i, m_lo, m_hi, p, pc, lo, pc_t, pc_c;
  logic signed [16:0] med_sum;
  logic signed [15:0] p0, p1, a0, a1, s0, s1, a_hi, a_lo;
  logic signed [16:0] d_a, d_p, d_den;
  logic [15:0]        mag_da, mag_dp, mag_den, dmag;
  logic               chan, neg, zden;
  logic [31:0]        prod;
  logic [32:0]        quo;
  logic [15:0]        rem, rem_n;
  logic [16:0]        sh;
  logic               ge;
  logic [5:0]         cnt;
  logic signed [35:0] q_s, lsum;
  logic signed [15:0] res, hood_res;
  logic signed [15:0] hood_out, speed_out, turret_out;
  logic               fire_out;

  assign rd_pitch = rdata[47:32];
  assign rd_angle = rdata[31:16];
  assign rd_speed = rdata[15:0];

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[wr_addr] <= {q_job.row_pitch, q_job.row_angle, q_job.row_speed};
    rdata <= row_mem[rd_addr];
  end

  always_comb begin
    if (rows_in_use < 5'd2) n_rows = NW'(2);
    else if (32'(rows_in_use) > TABLE_ROWS) n_rows = NW'(TABLE_ROWS);
    else n_rows = NW'(rows_in_use);
    last_row = AW'(n_rows - 1'b1);
    scan_end = AW'(n_rows - 2'd2);
    wr_addr = AW'(q_job.row_index);

    // rank of window entry med_i among the filled entries, ties by slot
    w_i = job.window[med_i];
    rank = '0;
    for (int j = 0; j < MEDIAN_TAPS; j++) begin
      if ((FILL_W'(j) < job.fill) &&
          (($signed(job.window[j]) < w_i) ||
           (($signed(job.window[j]) == w_i) && (SLOT_W'(j) < med_i))))
        rank = rank + 1'b1;
    end
    half = job.fill >> 1;
    med_sum = 17'(m_lo) + 17'(m_hi);

    pc_t = (p > rd_pitch) ? rd_pitch : p;
    pc_c = (pc_t < lo) ? lo : pc_t;

    a_hi = chan ? s1 : a1;
    a_lo = chan ? s0 : a0;
    d_a = 17'(a_hi) - 17'(a_lo);
    d_p = 17'(p) - 17'(p0);
    d_den = 17'(p1) - 17'(p0);
    mag_da = 16'(d_a[16] ? -d_a : d_a);
    mag_dp = 16'(d_p[16] ? -d_p : d_p);
    mag_den = 16'(d_den[16] ? -d_den : d_den);

    sh = {rem, quo[32]};
    ge = (sh >= {1'b0, dmag});
    rem_n = ge ? 16'(sh - {1'b0, dmag}) : sh[15:0];

    q_s = neg ? -36'(quo) : 36'(quo);
    lsum = 36'(a_lo) + q_s;
    res = zden ? a_lo : sat16(lsum);
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    mem_we = 1'b0;
    rd_addr = '0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_job.kind)
            JOB_WRITE: mem_we = (32'(q_job.row_index) < TABLE_ROWS);
            JOB_STOP: state_next = B_OUT;
            JOB_SAMPLE: state_next = B_MED;
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_MED: if (med_i == SLOT_W'(job.fill - 1'b1)) state_next = B_MEDFIN;
      B_MEDFIN: state_next = B_RD_HI;
      B_RD_HI: begin
        rd_addr = last_row;
        state_next = B_CLAMP;
      end
      B_CLAMP: state_next = B_SCAN;
      B_SCAN: begin
        rd_addr = scan_i + 1'b1;
        if (scan_i == scan_end) state_next = B_RD_SEG;
      end
      B_RD_SEG: begin
        rd_addr = seg;
        state_next = B_RD_SEG1;
      end
      B_RD_SEG1: begin
        rd_addr = seg + 1'b1;
        state_next = B_ROW1;
      end
      B_ROW1: state_next = B_MUL;
      B_MUL: state_next = (d_den == '0) ? B_FIX : B_DIVLOAD;
      B_DIVLOAD: state_next = B_DIV;
      B_DIV: if (cnt == 6'(DIV_STEPS - 1)) state_next = B_FIX;
      B_FIX: state_next = chan ? B_OUT : B_MUL;
      B_OUT: if (result.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          job <= q_job;
          med_i <= '0;
          if (q_job.kind == JOB_STOP) begin
            hood_out <= '0;
            speed_out <= '0;
            turret_out <= '0;
            fire_out <= 1'b0;
          end
        end
      end
      B_MED: begin
        if (rank == half) m_hi <= w_i;
        if (!job.fill[0] && rank == half - 1'b1) m_lo <= w_i;
        med_i <= med_i + 1'b1;
      end
      B_MEDFIN: p <= job.fill[0] ? m_hi : 16'(med_sum >>> 1);
      B_RD_HI: lo <= rd_pitch;
      B_CLAMP: begin
        pc <= pc_c;
        seg <= '0;
        scan_i <= '0;
      end
      B_SCAN: begin
        if (rd_pitch <= pc) seg <= scan_i;
        scan_i <= scan_i + 1'b1;
      end
      B_RD_SEG1: begin
        p0 <= rd_pitch;
        a0 <= rd_angle;
        s0 <= rd_speed;
      end
      B_ROW1: begin
        p1 <= rd_pitch;
        a1 <= rd_angle;
        s1 <= rd_speed;
        chan <= 1'b0;
      end
      B_MUL: begin
        zden <= (d_den == '0);
        prod <= mag_da * mag_dp;
        neg <= d_a[16] ^ d_p[16] ^ d_den[16];
        dmag <= mag_den;
      end
      B_DIVLOAD: begin
        quo <= {1'b0, prod} + 33'(dmag >> 1);
        rem <= '0;
        cnt <= '0;
      end
      B_DIV: begin
        rem <= rem_n;
        quo <= {quo[31:0], ge};
        cnt <= cnt + 1'b1;
      end
      B_FIX: begin
        if (!chan) begin
          hood_res <= res;
        end else begin
          hood_out <= hood_res;
          speed_out <= res;
          turret_out <= job.turret;
          fire_out <= job.fire;
        end
        chan <= 1'b1;
      end
      default: ;
    endcase
  end

  assign result.valid = (state == B_OUT);
  assign result.hood_setpoint = hood_out;
  assign result.wheel_speed = speed_out;
  assign result.turret_setpoint = turret_out;
  assign result.fire = fire_out;

endmodule
`default_nettype wire

### rtl/core/aim_table_interpolator.sv
// Sequence: a stop is popped from the queue and its zeroed result offered in B_OUT;
//   a target sample ranks its F median entries one a cycle, scans the N rows in use
//   one a cycle through the single row memory port and runs two 33-step divisions;
//   a zero-width segment skips its division.
// Throughput: one request in the queue per cycle while not full; the back end
//   finishes one sample at a time and pops no new job until its result is taken.
// Reset: config to defaults, median window and sample count cleared, queue empty;
//   table rows are undefined until written.
`default_nettype none
`include "aim_table_interpolator_assert.svh"
module aim_table_interpolator #(
  parameter int TABLE_ROWS = aim_ti_pkg::TABLE_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  aim_cfg_if.sink   cfg,
  aim_cmd_if.sink   cmd,
  aim_res_if.source result
);
  import aim_ti_pkg::*;

  logic [4:0]  rows_in_use;
  logic [14:0] fire_error_limit;
  logic [7:0]  settle_count;
  logic [7:0]  turret_gain;
  logic        q_push, q_pop, q_full, q_empty;
  job_t        push_job, pop_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 5'd16;
      fire_error_limit <= 15'd512;
      settle_count <= 8'd10;
      turret_gain <= 8'd128;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_ROWS: rows_in_use <= cfg.data[4:0];
        CFG_LIMIT: fire_error_limit <= cfg.data;
        CFG_SETTLE: settle_count <= cfg.data[7:0];
        CFG_GAIN: turret_gain <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  aim_ti_front u_front (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .fire_error_limit(fire_error_limit),
    .settle_count(settle_count),
    .turret_gain(turret_gain),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(push_job)
  );

  aim_ti_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(push_job),
    .pop(q_pop),
    .pop_job(pop_job),
    .full(q_full),
    .empty(q_empty)
  );

  aim_ti_back #(.TABLE_ROWS(TABLE_ROWS)) u_back (
    .clk(clk),
    .rst(rst),
    .rows_in_use(rows_in_use),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .q_job(pop_job),
    .result(result)
  );

  `AIM_ASSERT_IMP(a_no_push_when_full, q_full, !q_push)
  `AIM_ASSERT_IMP(a_no_pop_when_empty, q_empty, !q_pop)
  `AIM_ASSERT_NXT(a_result_drops_on_take, result.valid && result.ready, !result.valid)

endmodule
`default_nettype wire
